// File: sv/bsf_pkg.sv
// Shared types, constants and node tables of the biquadratic shape function unit.
`timescale 1ns / 1ps

package bsf_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 16;
	localparam int NODE_W     = 4;
	localparam int FAC_W      = IN_W + 1;
	localparam int DER_W      = IN_W + 2;
	localparam int FPROD_W    = 2 * FAC_W;
	localparam int MUL_W      = FAC_W + DER_W;

	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(8);

	// one-dimensional factor selectors: minus side, middle, plus side
	localparam logic [1:0] SEL_M = 2'd0;
	localparam logic [1:0] SEL_Z = 2'd1;
	localparam logic [1:0] SEL_P = 2'd2;

	// rounded factors and exact derivatives of one coordinate
	typedef struct packed {
		logic signed [FAC_W-1:0] fm;
		logic signed [FAC_W-1:0] fz;
		logic signed [FAC_W-1:0] fp;
		logic signed [DER_W-1:0] dm;
		logic signed [DER_W-1:0] dz;
		logic signed [DER_W-1:0] dp;
	} coord_fac_t;

	typedef struct packed {
		coord_fac_t c;
		coord_fac_t e;
	} point_fac_t;

	// operands of one node result on their way to the multipliers
	typedef struct packed {
		logic                    valid;
		logic [NODE_W-1:0]       node;
		logic                    last;
		logic signed [FAC_W-1:0] fa;
		logic signed [DER_W-1:0] da;
		logic signed [FAC_W-1:0] fb;
		logic signed [DER_W-1:0] db;
	} node_ops_t;

	function automatic logic [1:0] csi_sel(input logic [NODE_W-1:0] node);
		logic [1:0] s;
		unique case (node)
			4'd0, 4'd3, 4'd7: s = SEL_M;
			4'd4, 4'd6, 4'd8: s = SEL_Z;
			default:          s = SEL_P;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] eta_sel(input logic [NODE_W-1:0] node);
		logic [1:0] s;
		unique case (node)
			4'd0, 4'd1, 4'd4: s = SEL_M;
			4'd5, 4'd7, 4'd8: s = SEL_Z;
			default:          s = SEL_P;
		endcase
		return s;
	endfunction

endpackage

// File: sv/bsf_factor_pipe.sv
// Three-stage pipeline that forms the quadratic Lagrange factors of both coordinates.
`timescale 1ns / 1ps

module bsf_factor_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [bsf_pkg::IN_W-1:0] csi,
	input  logic signed [bsf_pkg::IN_W-1:0] eta,
	output logic                         in_ready,
	output logic                         out_valid,
	output bsf_pkg::point_fac_t          out_fac,
	input  logic                         out_ready
);
	import bsf_pkg::*;

	localparam logic signed [FAC_W-1:0]   ONE_F  = FAC_W'(1) <<< FRAC_BITS;
	localparam logic signed [DER_W-1:0]   HALF_D = DER_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [FPROD_W:0]   RND_H  = (FPROD_W + 1)'(1) <<< FRAC_BITS;
	localparam logic signed [FPROD_W:0]   RND_F  = (FPROD_W + 1)'(1) <<< (FRAC_BITS - 1);

	typedef struct packed {
		logic signed [FAC_W-1:0] x;
		logic signed [FAC_W-1:0] xm;
		logic signed [FAC_W-1:0] xp;
		logic signed [FAC_W-1:0] om;
	} sums_t;

	typedef struct packed {
		logic signed [FAC_W-1:0]   x;
		logic signed [FPROD_W-1:0] pm;
		logic signed [FPROD_W-1:0] pz;
		logic signed [FPROD_W-1:0] pp;
	} prods_t;

	function automatic sums_t form_sums(input logic signed [IN_W-1:0] v);
		sums_t r;
		r.x  = FAC_W'(v);
		r.xm = r.x - ONE_F;
		r.xp = r.x + ONE_F;
		r.om = ONE_F - r.x;
		return r;
	endfunction

	function automatic prods_t form_prods(input sums_t s);
		prods_t r;
		r.x  = s.x;
		r.pm = FPROD_W'(s.x) * FPROD_W'(s.xm);
		r.pz = FPROD_W'(s.om) * FPROD_W'(s.xp);
		r.pp = FPROD_W'(s.x) * FPROD_W'(s.xp);
		return r;
	endfunction

	function automatic coord_fac_t form_factors(input prods_t p);
		coord_fac_t            r;
		logic signed [FPROD_W:0] sm;
		logic signed [FPROD_W:0] sz;
		logic signed [FPROD_W:0] sp;
		logic signed [DER_W-1:0] xd;
		sm   = (FPROD_W + 1)'(p.pm) + RND_H;
		sz   = (FPROD_W + 1)'(p.pz) + RND_F;
		sp   = (FPROD_W + 1)'(p.pp) + RND_H;
		sm   = sm >>> (FRAC_BITS + 1);
		sz   = sz >>> FRAC_BITS;
		sp   = sp >>> (FRAC_BITS + 1);
		r.fm = sm[FAC_W-1:0];
		r.fz = sz[FAC_W-1:0];
		r.fp = sp[FAC_W-1:0];
		xd   = DER_W'(p.x);
		r.dm = xd - HALF_D;
		r.dz = DER_W'(0) - (xd <<< 1);
		r.dp = xd + HALF_D;
		return r;
	endfunction

	logic   v_s1, v_s2, v_s3;
	logic   en_s1, en_s2, en_s3;
	sums_t  c_s1, e_s1;
	prods_t c_s2, e_s2;
	point_fac_t fac_s3;

	// a stage takes new data when it is empty or its contents move on
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s1 <= form_sums(csi);
			e_s1 <= form_sums(eta);
		end
		if (en_s2) begin
			c_s2 <= form_prods(c_s1);
			e_s2 <= form_prods(e_s1);
		end
		if (en_s3) begin
			fac_s3.c <= form_factors(c_s2);
			fac_s3.e <= form_factors(e_s2);
		end
	end

	assign out_valid = v_s3;
	assign out_fac   = fac_s3;

endmodule

// File: sv/bsf_node_seq.sv
// Holds one point's factors and steps through the nine nodes, one per cycle.
`timescale 1ns / 1ps

module bsf_node_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fac_valid,
	input  bsf_pkg::point_fac_t fac,
	output logic                fac_ready,
	output bsf_pkg::node_ops_t  ops
);
	import bsf_pkg::*;

	function automatic logic signed [FAC_W-1:0] pick_f(input coord_fac_t cf,
			input logic [1:0] s);
		logic signed [FAC_W-1:0] r;
		unique case (s)
			SEL_M:   r = cf.fm;
			SEL_Z:   r = cf.fz;
			default: r = cf.fp;
		endcase
		return r;
	endfunction

	function automatic logic signed [DER_W-1:0] pick_d(input coord_fac_t cf,
			input logic [1:0] s);
		logic signed [DER_W-1:0] r;
		unique case (s)
			SEL_M:   r = cf.dm;
			SEL_Z:   r = cf.dz;
			default: r = cf.dp;
		endcase
		return r;
	endfunction

	point_fac_t              hold_q;
	logic                    hold_v_q;
	logic [NODE_W-1:0]       cnt_q;
	logic                    at_last;
	logic                    load;
	logic [1:0]              sa, sb;
	logic                    v_s4;
	logic [NODE_W-1:0]       node_s4;
	logic                    last_s4;
	logic signed [FAC_W-1:0] fa_s4, fb_s4;
	logic signed [DER_W-1:0] da_s4, db_s4;

	assign at_last   = (cnt_q == LAST_NODE);
	assign load      = fac_valid && (!hold_v_q || at_last);
	assign fac_ready = !hold_v_q || at_last;
	assign sa        = csi_sel(cnt_q);
	assign sb        = eta_sel(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			cnt_q    <= '0;
			v_s4     <= 1'b0;
		end else begin
			v_s4 <= hold_v_q;
			if (load) begin
				hold_v_q <= 1'b1;
				cnt_q    <= '0;
			end else if (hold_v_q) begin
				if (at_last) begin
					hold_v_q <= 1'b0;
					cnt_q    <= '0;
				end else begin
					cnt_q <= cnt_q + NODE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) hold_q <= fac;
		node_s4 <= cnt_q;
		last_s4 <= at_last;
		fa_s4   <= pick_f(hold_q.c, sa);
		da_s4   <= pick_d(hold_q.c, sa);
		fb_s4   <= pick_f(hold_q.e, sb);
		db_s4   <= pick_d(hold_q.e, sb);
	end

	// field order of node_ops_t
	assign ops = {v_s4, node_s4, last_s4, fa_s4, da_s4, fb_s4, db_s4};

endmodule

// File: sv/bsf_node_math.sv
// Multiplies the selected factors of a node, then rounds and saturates the results.
`timescale 1ns / 1ps

module bsf_node_math (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsf_pkg::node_ops_t             ops,
	output logic                           strobe,
	output logic [bsf_pkg::NODE_W-1:0]     node,
	output logic signed [bsf_pkg::OUT_W-1:0] shape_value,
	output logic signed [bsf_pkg::OUT_W-1:0] deriv_csi,
	output logic signed [bsf_pkg::OUT_W-1:0] deriv_eta,
	output logic                           last
);
	import bsf_pkg::*;

	localparam logic signed [MUL_W:0] RND    = (MUL_W + 1)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [MUL_W:0] SAT_HI = (MUL_W + 1)'((1 <<< (OUT_W - 1)) - 1);
	localparam logic signed [MUL_W:0] SAT_LO = -((MUL_W + 1)'(1) <<< (OUT_W - 1));

	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [MUL_W-1:0] p);
		logic signed [MUL_W:0] s;
		logic signed [OUT_W-1:0] r;
		s = (MUL_W + 1)'(p) + RND;
		s = s >>> FRAC_BITS;
		priority if (s > SAT_HI) r = SAT_HI[OUT_W-1:0];
		else if (s < SAT_LO)     r = SAT_LO[OUT_W-1:0];
		else                     r = s[OUT_W-1:0];
		return r;
	endfunction

	logic                    v_s5;
	logic [NODE_W-1:0]       node_s5;
	logic                    last_s5;
	logic signed [MUL_W-1:0] pv_s5, pc_s5, pe_s5;

	logic                    v_s6;
	logic [NODE_W-1:0]       node_s6;
	logic                    last_s6;
	logic signed [OUT_W-1:0] val_s6, dc_s6, de_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s5 <= ops.valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		node_s5 <= ops.node;
		last_s5 <= ops.last;
		pv_s5   <= MUL_W'(ops.fa) * MUL_W'(ops.fb);
		pc_s5   <= MUL_W'(ops.da) * MUL_W'(ops.fb);
		pe_s5   <= MUL_W'(ops.fa) * MUL_W'(ops.db);
		node_s6 <= node_s5;
		last_s6 <= last_s5;
		val_s6  <= round_sat(pv_s5);
		dc_s6   <= round_sat(pc_s5);
		de_s6   <= round_sat(pe_s5);
	end

	assign strobe      = v_s6;
	assign node        = node_s6;
	assign last        = v_s6 && last_s6;
	assign shape_value = val_s6;
	assign deriv_csi   = dc_s6;
	assign deriv_eta   = de_s6;

endmodule

// File: sv/biquadratic_shape_functions_unit.sv
// Top level of the nine-node biquadratic quadrilateral shape function unit.
`timescale 1ns / 1ps

// Use:
//   Command side: drive csi and eta (Q2.14 signed) and raise start; the point
//   transfers at a rising edge where start is high and busy is low.
//   Result side: each point gives nine results, nodes 0..8 in order (corners,
//   mid-sides, centre), one per cycle on consecutive cycles. Each result is on
//   node, shape_value, deriv_csi, deriv_eta and last for exactly one cycle
//   while strobe is high; last marks node 8. All three values saturate at the
//   Q2.14 limits.
// Path: a point passes the three factor stages and is held in the node
//   sequencer; each node result then passes the product and round stages.
// Throughput: the node sequencer takes a new point only when it is idle or
//   issues node 8 of the last one, and issues one node per cycle to a single
//   set of three multipliers. The factor pipeline keeps taking points while
//   earlier ones are emitted; busy rises only when all three factor stages
//   are full behind the sequencer.
// Reset: arst_n clears all valid bits and the node counter; no results are
//   in flight afterwards and busy is low.
// The receiver cannot stall: every strobe is a completed transfer.

module biquadratic_shape_functions_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [bsf_pkg::IN_W-1:0]   csi,
	input  logic signed [bsf_pkg::IN_W-1:0]   eta,
	output logic                              strobe,
	output logic [bsf_pkg::NODE_W-1:0]        node,
	output logic signed [bsf_pkg::OUT_W-1:0]  shape_value,
	output logic signed [bsf_pkg::OUT_W-1:0]  deriv_csi,
	output logic signed [bsf_pkg::OUT_W-1:0]  deriv_eta,
	output logic                              last
);
	import bsf_pkg::*;

	logic       in_ready;
	logic       fac_valid;
	logic       fac_ready;
	point_fac_t fac;
	node_ops_t  ops;

	// hold off new commands only when the first factor stage cannot advance
	assign busy = !in_ready;

	// stages 1-3: coordinate sums, factor products, rounded factors
	bsf_factor_pipe u_factor_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.csi       (csi),
		.eta       (eta),
		.in_ready  (in_ready),
		.out_valid (fac_valid),
		.out_fac   (fac),
		.out_ready (fac_ready)
	);

	// stage 4: hold the point and select the factor pair of each node
	bsf_node_seq u_node_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fac_valid (fac_valid),
		.fac       (fac),
		.fac_ready (fac_ready),
		.ops       (ops)
	);

	// stages 5-6: node products, then round and saturate into the result ports
	bsf_node_math u_node_math (
		.clk         (clk),
		.arst_n      (arst_n),
		.ops         (ops),
		.strobe      (strobe),
		.node        (node),
		.shape_value (shape_value),
		.deriv_csi   (deriv_csi),
		.deriv_eta   (deriv_eta),
		.last        (last)
	);

endmodule
